/* src/bps_pkg.sv */
// Shared types and constants of the buzzer pattern sequencer.
package bps_pkg;

    localparam int TICK_W     = 11;
    localparam int PLAY_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [PLAY_W-1:0] WARNING_PLAYS_RST = 8'd15;
    localparam logic [PLAY_W-1:0] LONG_PLAYS_RST    = 8'd101;

    typedef enum logic [2:0] {
        PAT_OFF         = 3'd0,
        PAT_LOCK        = 3'd1,
        PAT_NORMAL      = 3'd2,
        PAT_ON_OFF      = 3'd3,
        PAT_WARNING     = 3'd4,
        PAT_SUCCESS     = 3'd5,
        PAT_ALARM       = 3'd6,
        PAT_INPUT_ERROR = 3'd7
    } t_pattern;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARNING_PLAYS = 1'd0,
        CFG_LONG_PLAYS    = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        t_pattern          active;
        t_pattern          prev;
        logic [TICK_W-1:0] tick;
        logic [PLAY_W-1:0] play;
        logic              level;
    } t_state;

    typedef struct packed {
        logic [PLAY_W-1:0] warning_plays;
        logic [PLAY_W-1:0] long_plays;
    } t_cfg;

endpackage

/* src/bps_in_if.sv */
// Input item channel: tick or pattern load.
interface bps_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [2:0] pattern_sel;

    modport source (output valid, output op, output pattern_sel, input ready);
    modport sink   (input valid, input op, input pattern_sel, output ready);
endinterface

/* src/bps_out_if.sv */
// Result item channel: buzzer level and active pattern.
interface bps_out_if;
    logic       valid;
    logic       ready;
    logic       buzzer_on;
    logic [2:0] current_pattern;

    modport source (output valid, output buzzer_on, output current_pattern, input ready);
    modport sink   (input valid, input buzzer_on, input current_pattern, output ready);
endinterface

/* src/bps_cfg.sv */
// Configuration registers: play limits of the repeating patterns.
module bps_cfg import bps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warning_plays <= WARNING_PLAYS_RST;
            r_cfg.long_plays    <= LONG_PLAYS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WARNING_PLAYS: r_cfg.warning_plays <= i_cfg_data[PLAY_W-1:0];
                CFG_LONG_PLAYS:    r_cfg.long_plays    <= i_cfg_data[PLAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/bps_step.sv */
// Next-state logic for one item: pattern load or one time tick.
module bps_step import bps_pkg::*; #(
    parameter int MS_PER_TICK = 10
) (
    input  t_state   i_state,
    input  t_cfg     i_cfg,
    input  logic     i_op,
    input  t_pattern i_sel,
    output t_state   o_state
);

    localparam logic [TICK_W-1:0] TK_100  = TICK_W'(100 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_150  = TICK_W'(150 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_200  = TICK_W'(200 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_250  = TICK_W'(250 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_300  = TICK_W'(300 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_350  = TICK_W'(350 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_500  = TICK_W'(500 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_550  = TICK_W'(550 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_650  = TICK_W'(650 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_700  = TICK_W'(700 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_950  = TICK_W'(950 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_1050 = TICK_W'(1050 / MS_PER_TICK);
    localparam logic [TICK_W-1:0] TK_1500 = TICK_W'(1500 / MS_PER_TICK);

    logic              restart;
    logic [TICK_W-1:0] t_base;
    logic [TICK_W-1:0] t_cur;
    logic              lvl;
    logic [PLAY_W-1:0] pl;
    logic [PLAY_W-1:0] limit;
    logic              tick_clr;
    logic              period_end;
    logic              repeating;

    always_comb begin
        o_state    = i_state;
        restart    = 1'b0;
        t_base     = '0;
        t_cur      = '0;
        lvl        = 1'b0;
        pl         = '0;
        limit      = '0;
        tick_clr   = 1'b0;
        period_end = 1'b0;
        repeating  = 1'b0;
        if (i_op) begin
            o_state.active = i_sel;
        end else begin
            case (i_state.active)
                PAT_OFF: begin
                    o_state = '0;
                end
                PAT_LOCK: begin
                    o_state.tick = '0;
                    o_state.play = '0;
                end
                default: begin
                    restart       = (i_state.prev != i_state.active);
                    t_base        = restart ? '0 : i_state.tick;
                    lvl           = restart ? 1'b0 : i_state.level;
                    pl            = restart ? '0 : i_state.play;
                    o_state.prev  = i_state.active;
                    case (i_state.active)
                        PAT_NORMAL, PAT_ON_OFF: begin
                            if (t_base == '0) begin
                                lvl = 1'b1;
                            end else if (t_base == TK_100) begin
                                lvl = 1'b0; tick_clr = 1'b1;
                            end
                        end
                        PAT_SUCCESS: begin
                            if (t_base == '0) begin
                                lvl = 1'b1;
                            end else if (t_base == TK_200) begin
                                lvl = 1'b0; tick_clr = 1'b1;
                            end
                        end
                        PAT_WARNING: begin
                            repeating = 1'b1;
                            limit     = i_cfg.warning_plays;
                            if (t_base == '0) begin
                                lvl = 1'b1;
                            end else if (t_base == TK_100) begin
                                lvl = 1'b0;
                            end else if (t_base == TK_150) begin
                                lvl = 1'b1;
                            end else if (t_base == TK_250) begin
                                lvl = 1'b0;
                            end else if (t_base == TK_350) begin
                                lvl = 1'b0; tick_clr = 1'b1; period_end = 1'b1;
                            end
                        end
                        PAT_ALARM: begin
                            repeating = 1'b1;
                            limit     = i_cfg.long_plays;
                            if (t_base == '0) begin
                                lvl = 1'b1;
                            end else if (t_base == TK_250) begin
                                lvl = 1'b0;
                            end else if (t_base == TK_500) begin
                                lvl = 1'b1;
                            end else if (t_base == TK_700) begin
                                lvl = 1'b0;
                            end else if (t_base == TK_950) begin
                                lvl = 1'b1;
                            end else if (t_base == TK_1050) begin
                                lvl = 1'b0;
                            end else if (t_base == TK_1500) begin
                                lvl = 1'b0; tick_clr = 1'b1; period_end = 1'b1;
                            end
                        end
                        default: begin
                            repeating = 1'b1;
                            limit     = i_cfg.long_plays;
                            if (t_base == '0) begin
                                lvl = 1'b1;
                            end else if (t_base == TK_300) begin
                                lvl = 1'b0;
                            end else if (t_base == TK_350) begin
                                lvl = 1'b1;
                            end else if (t_base == TK_550) begin
                                lvl = 1'b0;
                            end else if (t_base == TK_650) begin
                                lvl = 1'b0; tick_clr = 1'b1; period_end = 1'b1;
                            end
                        end
                    endcase
                    t_cur = tick_clr ? '0 : t_base;
                    // count a play at step zero; stop at the limit, else replay
                    if (repeating && (t_cur == '0)) begin
                        pl = pl + PLAY_W'(1);
                        if (pl >= limit) begin
                            pl  = '0;
                            lvl = 1'b0;
                        end else if (period_end) begin
                            lvl = 1'b1;
                        end
                    end
                    o_state.level = lvl;
                    o_state.play  = pl;
                    if ((t_cur == '0) && (pl == '0) && !lvl) begin
                        o_state.active = PAT_OFF;
                        o_state.tick   = t_cur;
                    end else begin
                        o_state.tick = t_cur + TICK_W'(1);
                    end
                end
            endcase
        end
    end

endmodule

/* src/buzzer_pattern_sequencer_core.sv */
// Top level of the buzzer pattern sequencer: input stage, state, result register.
//
//   channel    | direction | payload                      | accepted when
//   i_item     | in        | op, pattern_sel              | valid && ready
//   o_result   | out       | buzzer_on, current_pattern   | valid && ready
//   i_cfg_*    | in        | warning_plays, long_plays    | i_cfg_we
//
// One item per cycle while results are taken; a result is valid once its item has
// passed the input register, then the next-state logic into the state and result registers.
// Reset is synchronous, active low; limits return to 15 and 101, state to off.
// A held result stalls the step; the input register then fills and i_item.ready drops.
module buzzer_pattern_sequencer_core import bps_pkg::*; #(
    parameter int MS_PER_TICK = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bps_in_if.sink                i_item,
    bps_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       cfg;
    t_state     r_state;
    t_state     n_state;
    logic       r_in_valid;
    logic       r_in_op;
    logic [2:0] r_in_sel;
    logic       r_out_valid;
    logic       r_out_buzzer;
    t_pattern   r_out_pattern;
    logic       fire;
    logic       in_take;

    bps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bps_step #(.MS_PER_TICK(MS_PER_TICK)) u_step (
        .i_state (r_state),
        .i_cfg   (cfg),
        .i_op    (r_in_op),
        .i_sel   (t_pattern'(r_in_sel)),
        .o_state (n_state)
    );

    assign fire           = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || fire;
    assign in_take        = i_item.valid && i_item.ready;

    assign o_result.valid           = r_out_valid;
    assign o_result.buzzer_on       = r_out_buzzer;
    assign o_result.current_pattern = r_out_pattern;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op  <= i_item.op;
            r_in_sel <= i_item.pattern_sel;
        end
        if (fire) begin
            r_out_buzzer  <= n_state.level;
            r_out_pattern <= n_state.active;
        end
    end

`ifndef SYNTHESIS
    a_result_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out_pattern == r_state.active) && (r_out_buzzer == r_state.level))
        else $error("result register differs from state after step");

    a_off_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_in_op && (r_state.active == PAT_OFF)) |=> (r_state == '0))
        else $error("tick while off left state behind");

    a_lock_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_in_op && (r_state.active == PAT_LOCK)) |=>
            (r_state.tick == '0) && (r_state.play == '0) &&
            (r_state.level == $past(r_state.level)))
        else $error("lock tick did not hold level and clear counters");

    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid && $stable(r_in_op) && $stable(r_in_sel))
        else $error("stalled item lost from input register");
`endif

endmodule
